/* rtl/duart_pkg.sv */
// Shared types, constants and register offsets for the dual UART with timer.
// Used by duart_mod, duart_ctrl, duart_dp and dual_uart_with_timer; no dependencies.
`default_nettype none
package duart_pkg;
    localparam int TICK_CLOCKS = 184;
    localparam logic [15:0] TICK_X1 = 16'(TICK_CLOCKS);
    localparam logic [15:0] TICK_X16 = 16'(TICK_CLOCKS / 16);

    localparam logic [2:0] FUNC_READ = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_TICK = 3'd2;
    localparam logic [2:0] FUNC_PIN_SET = 3'd3;
    localparam logic [2:0] FUNC_PIN_CLR = 3'd4;

    localparam logic [3:0] REG_MODE_A = 4'h0;
    localparam logic [3:0] REG_STAT_A = 4'h1;
    localparam logic [3:0] REG_CMD_A = 4'h2;
    localparam logic [3:0] REG_DATA_A = 4'h3;
    localparam logic [3:0] REG_AUX = 4'h4;
    localparam logic [3:0] REG_ISR = 4'h5;
    localparam logic [3:0] REG_CNT_HI = 4'h6;
    localparam logic [3:0] REG_CNT_LO = 4'h7;
    localparam logic [3:0] REG_MODE_B = 4'h8;
    localparam logic [3:0] REG_STAT_B = 4'h9;
    localparam logic [3:0] REG_CMD_B = 4'hA;
    localparam logic [3:0] REG_DATA_B = 4'hB;
    localparam logic [3:0] REG_VECTOR = 4'hC;
    localparam logic [3:0] REG_PORT = 4'hD;
    localparam logic [3:0] REG_START = 4'hE;
    localparam logic [3:0] REG_STOP = 4'hF;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] addr;
        logic [7:0] wdata;
        logic       rx_avail;
        logic       tx_room;
        logic [7:0] rx_byte;
        logic [2:0] pin;
    } req_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;    // latch request and run its one-cycle event
        logic wrap;    // finish counter underflow with the modulo result
    } cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic wrap_pending;
        logic mod_done;
    } stat_t;
endpackage
`default_nettype wire

/* rtl/duart_mod.sv */
// Iterative restoring remainder unit: 16-bit dividend modulo 16-bit divisor.
// Depends on nothing but the package; one quotient bit per cycle.
`default_nettype none
module duart_mod
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic      [15:0] remainder
);
    import duart_pkg::*;

    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] div_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    assign trial = {rem_reg, quo_reg[15]} - {1'b0, div_reg};

    // Shift one dividend bit in and subtract where it fits
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
                rem_next = trial[15:0];
            else
                rem_next = {rem_reg[14:0], quo_reg[15]};
            quo_next = {quo_reg[14:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            div_reg <= divisor;
    end

    assign done = busy_reg && (cnt_reg == 5'd1);
    assign remainder = (!trial[16]) ? trial[15:0] : {rem_reg[14:0], quo_reg[15]};
endmodule
`default_nettype wire

/* rtl/duart_dp.sv */
// Datapath: register file, event logic, counter and result register.
// Depends on duart_pkg and duart_mod.
`default_nettype none
module duart_dp
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            console_port,
    input  wire duart_pkg::req_t       req,
    input  wire duart_pkg::cmd_t       cmd,
    output duart_pkg::stat_t           stat,
    output logic [47:0]                result
);
    import duart_pkg::*;

    logic [7:0]  mode_one_reg [2];
    logic [7:0]  mode_two_reg [2];
    logic [1:0]  mode_ptr_reg, mode_ptr_next;
    logic [7:0]  status_reg [2];
    logic [7:0]  status_next [2];
    logic [7:0]  rxh_reg [2];
    logic [1:0]  txdis_reg, txdis_next;
    logic [1:0]  rxdis_reg, rxdis_next;
    logic [7:0]  ipcr_reg, ipcr_next;
    logic [7:0]  isr_reg, isr_next;
    logic [7:0]  imr_reg, imr_next;
    logic [7:0]  ivr_reg, ivr_next;
    logic [7:0]  acr_reg, acr_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] pre_reg, pre_next;
    logic        stop_reg, stop_next;
    logic [7:0]  op_reg, op_next;
    logic [5:0]  pins_reg, pins_next;
    logic        wrap_reg, wrap_next;
    logic [47:0] res_reg, res_next;

    logic        ch;
    logic [7:0]  rdata;
    logic        changed, tx_hit;
    logic [7:0]  tx_data;
    logic [7:0]  lines;
    logic        mod_start, mod_done;
    logic [15:0] deficit, mod_rem, step;
    logic [2:0]  cmode;
    logic        run;
    logic [7:0]  pm;

    assign ch = req.addr[3];
    assign cmode = acr_reg[6:4];
    assign step = (cmode == 3'd6) ? TICK_X1 : TICK_X16;
    assign run = (acr_reg[6] || !stop_reg)
        && (cmode == 3'd3 || cmode == 3'd7 || cmode == 3'd6);
    assign deficit = step - cnt_reg;
    assign pm = 8'(1) << req.pin;

    duart_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (deficit),
        .divisor   (pre_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign stat.wrap_pending = wrap_reg;
    assign stat.mod_done = mod_done;

    // Run one event against the register file
    always_comb
    begin
        mode_ptr_next = mode_ptr_reg;
        status_next = status_reg;
        txdis_next = txdis_reg;
        rxdis_next = rxdis_reg;
        ipcr_next = ipcr_reg;
        isr_next = isr_reg;
        imr_next = imr_reg;
        ivr_next = ivr_reg;
        acr_next = acr_reg;
        cnt_next = cnt_reg;
        pre_next = pre_reg;
        stop_next = stop_reg;
        op_next = op_reg;
        pins_next = pins_reg;
        wrap_next = 1'b0;
        mod_start = 1'b0;
        rdata = 8'hFF;
        changed = 1'b0;
        tx_hit = 1'b0;
        tx_data = 8'h00;
        if (cmd.load)
        begin
            unique case (req.func)
                FUNC_READ:
                begin
                    unique case (req.addr)
                        REG_MODE_A, REG_MODE_B:
                        begin
                            if (mode_ptr_reg[ch])
                                rdata = mode_two_reg[ch];
                            else
                            begin
                                mode_ptr_next[ch] = 1'b1;
                                rdata = mode_one_reg[ch];
                            end
                        end
                        REG_STAT_A, REG_STAT_B: rdata = status_reg[ch];
                        REG_CMD_A, REG_DATA_A, REG_CMD_B, REG_DATA_B:
                        begin
                            if (status_reg[ch][0])
                            begin
                                status_next[ch][0] = 1'b0;
                                if (ch)
                                    isr_next[5] = 1'b0;
                                else
                                    isr_next[1] = 1'b0;
                            end
                            rdata = rxh_reg[ch];
                        end
                        REG_AUX:
                        begin
                            ipcr_next = ipcr_reg & 8'h0F;
                            isr_next = isr_reg & 8'h7F;
                            rdata = ipcr_reg & 8'h0F;
                        end
                        REG_ISR: rdata = isr_reg;
                        REG_CNT_HI: rdata = cnt_reg[15:8];
                        REG_CNT_LO: rdata = cnt_reg[7:0];
                        REG_VECTOR: rdata = ivr_reg;
                        REG_PORT: rdata = {2'b00, pins_reg};
                        REG_START:
                        begin
                            cnt_next = pre_reg;
                            stop_next = 1'b0;
                        end
                        REG_STOP:
                        begin
                            stop_next = 1'b1;
                            isr_next[3] = 1'b0;
                        end
                        default: ;
                    endcase
                end
                FUNC_WRITE:
                begin
                    unique case (req.addr)
                        REG_CMD_A, REG_CMD_B:
                        begin
                            unique case (req.wdata[6:4])
                                3'd1: mode_ptr_next[ch] = 1'b0;
                                3'd2: rxdis_next[ch] = 1'b1;
                                3'd4: status_next[ch] = status_reg[ch] & 8'h0F;
                                3'd5:
                                begin
                                    if (ch)
                                        isr_next[6] = 1'b0;
                                    else
                                        isr_next[2] = 1'b0;
                                end
                                default: ;
                            endcase
                            if (req.wdata[0]) rxdis_next[ch] = 1'b0;
                            if (req.wdata[1]) rxdis_next[ch] = 1'b1;
                            if (req.wdata[2]) txdis_next[ch] = 1'b0;
                            if (req.wdata[3]) txdis_next[ch] = 1'b1;
                        end
                        REG_DATA_A, REG_DATA_B:
                        begin
                            if (ch)
                                isr_next[4] = 1'b0;
                            else
                                isr_next[0] = 1'b0;
                            if (!txdis_reg[ch] && status_reg[ch][2])
                            begin
                                if (console_port == {ch, !ch})
                                begin
                                    tx_hit = 1'b1;
                                    tx_data = req.wdata;
                                end
                                status_next[ch] = status_reg[ch] & 8'hF3;
                            end
                        end
                        REG_AUX: acr_next = req.wdata;
                        REG_ISR: imr_next = req.wdata;
                        REG_CNT_HI: pre_next = {req.wdata, pre_reg[7:0]};
                        REG_CNT_LO: pre_next = {pre_reg[15:8], req.wdata};
                        REG_VECTOR: ivr_next = req.wdata;
                        REG_START:
                        begin
                            op_next = op_reg | req.wdata;
                            changed = 1'b1;
                        end
                        REG_STOP:
                        begin
                            op_next = op_reg & ~req.wdata;
                            changed = 1'b1;
                        end
                        // Clock select and output port config drive no output; drop them
                        default: ;
                    endcase
                end
                FUNC_TICK:
                begin
                    if (req.tx_room)
                    begin
                        if (!txdis_reg[0] && !status_reg[0][2]) isr_next[0] = 1'b1;
                        if (!txdis_reg[1] && !status_reg[1][2]) isr_next[4] = 1'b1;
                        status_next[0] = status_reg[0] | 8'h0C;
                        status_next[1] = status_reg[1] | 8'h0C;
                    end
                    if (req.rx_avail)
                    begin
                        if (console_port == 2'd1 && !rxdis_reg[0])
                        begin
                            status_next[0][0] = 1'b1;
                            isr_next[1] = 1'b1;
                        end
                        else if (console_port == 2'd2 && !rxdis_reg[1])
                        begin
                            status_next[1][0] = 1'b1;
                            isr_next[5] = 1'b1;
                        end
                    end
                    if (run)
                    begin
                        if (cnt_reg >= step)
                            cnt_next = cnt_reg - step;
                        else
                        begin
                            isr_next[3] = 1'b1;
                            if (pre_reg == 16'h0000)
                                cnt_next = '0;
                            else
                            begin
                                mod_start = 1'b1;
                                wrap_next = 1'b1;
                            end
                        end
                    end
                end
                FUNC_PIN_SET, FUNC_PIN_CLR:
                begin
                    if (req.pin <= 3'd5)
                    begin
                        if (req.pin <= 3'd3)
                        begin
                            if (pins_reg[req.pin] != (req.func == FUNC_PIN_SET))
                            begin
                                ipcr_next[{1'b1, req.pin[1:0]}] = 1'b1;
                                isr_next[7] = 1'b1;
                            end
                            ipcr_next[{1'b0, req.pin[1:0]}] = (req.func == FUNC_PIN_SET);
                        end
                        if (req.func == FUNC_PIN_SET)
                            pins_next = pins_reg | pm[5:0];
                        else
                            pins_next = pins_reg & ~pm[5:0];
                    end
                end
                default: ;
            endcase
        end
        else if (cmd.wrap)
        begin
            cnt_next = pre_reg - mod_rem;
        end
        else
            wrap_next = wrap_reg;
    end

    assign lines = isr_next & imr_next;

    // Capture the result fields on an event; hold them until taken
    always_comb
    begin
        res_next = res_reg;
        if (cmd.load)
            res_next = {5'b0, ivr_next, changed, op_next, tx_data, tx_hit,
                        (lines != 8'h00), lines, rdata};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_ptr_reg <= '0;
            status_reg[0] <= '0;
            status_reg[1] <= '0;
            txdis_reg <= '0;
            rxdis_reg <= '0;
            ipcr_reg <= '0;
            isr_reg <= '0;
            imr_reg <= '0;
            ivr_reg <= 8'h0F;
            acr_reg <= 8'hFF;
            cnt_reg <= '0;
            pre_reg <= 16'hFFFF;
            stop_reg <= 1'b0;
            op_reg <= '0;
            pins_reg <= '0;
            wrap_reg <= 1'b0;
            mode_one_reg[0] <= '0;
            mode_one_reg[1] <= '0;
            mode_two_reg[0] <= '0;
            mode_two_reg[1] <= '0;
            rxh_reg[0] <= '0;
            rxh_reg[1] <= '0;
        end
        else
        begin
            mode_ptr_reg <= mode_ptr_next;
            status_reg <= status_next;
            txdis_reg <= txdis_next;
            rxdis_reg <= rxdis_next;
            ipcr_reg <= ipcr_next;
            isr_reg <= isr_next;
            imr_reg <= imr_next;
            ivr_reg <= ivr_next;
            acr_reg <= acr_next;
            cnt_reg <= cnt_next;
            pre_reg <= pre_next;
            stop_reg <= stop_next;
            op_reg <= op_next;
            pins_reg <= pins_next;
            wrap_reg <= wrap_next;
            // Mode and receive holding writes
            if (cmd.load && req.func == FUNC_WRITE)
            begin
                if (req.addr == REG_MODE_A || req.addr == REG_MODE_B)
                begin
                    if (mode_ptr_reg[ch])
                        mode_two_reg[ch] <= req.wdata;
                    else
                        mode_one_reg[ch] <= req.wdata;
                end
            end
            if (cmd.load && req.func == FUNC_TICK && req.rx_avail)
            begin
                if (console_port == 2'd1 && !rxdis_reg[0])
                    rxh_reg[0] <= req.rx_byte;
                else if (console_port == 2'd2 && !rxdis_reg[1])
                    rxh_reg[1] <= req.rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;
endmodule
`default_nettype wire

/* rtl/duart_ctrl.sv */
// Controller: stream handshake and sequencing of event and counter wrap.
// Depends on duart_pkg.
`default_nettype none
module duart_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output duart_pkg::cmd_t       cmd,
    input  wire duart_pkg::stat_t stat
);
    import duart_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WRAP = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take = in_valid && in_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign cmd.load = take;
    assign cmd.wrap = (state_reg == ST_WRAP) && stat.mod_done;

    // Sequence: accept, optional modulo wait, hold result until taken
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = ST_WRAP;
            ST_WRAP:
            begin
                if (!stat.wrap_pending || stat.mod_done)
                    state_next = ST_FULL;
            end
            ST_FULL: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

/* rtl/dual_uart_with_timer.sv */
// Top level of the dual UART with counter/timer.
// Depends on duart_pkg, duart_ctrl, duart_dp and duart_mod.
//
// Requests enter on s_axis (tvalid/tready/tdata); one result leaves on m_axis
// per request. cfg_we/cfg_wdata write the console selection; the user must
// do so only while idle, as the block itself does not enforce it. A result
// is captured when its request is accepted and is offered once the controller
// leaves its wait state; a tick that underflows the counter with a nonzero
// preload runs the 16-step remainder unit, and its result is offered once
// the remainder is done. The next request can be accepted in the cycle after
// the result is taken, never before.
// Reset (rst_n low, asynchronous) sets vector 0x0F, aux control 0xFF, preload
// 0xFFFF, other control registers zero; result and remainder data are not reset.
// While a result waits and m_axis_tready is low, the result holds and s_axis_tready stays low.
`default_nettype none
module dual_uart_with_timer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // func[2:0], addr[6:3], wdata[14:7], rx_avail[15], tx_room[16],
    // rx_byte[24:17], pin[27:25], zero fill [31:28]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // rdata[7:0], irq_lines[15:8], irq_request[16], tx_valid[17],
    // tx_byte[25:18], out_pins[33:26], out_changed[34], vector[42:35], zero [47:43]
    output logic [47:0]      m_axis_tdata
);
    import duart_pkg::*;

    logic [1:0] console_reg;
    req_t       req;
    cmd_t       cmd;
    stat_t      stat;
    logic [47:0] res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            console_reg <= '0;
        else if (cfg_we)
            console_reg <= cfg_wdata;
    end

    assign req.func = s_axis_tdata[2:0];
    assign req.addr = s_axis_tdata[6:3];
    assign req.wdata = s_axis_tdata[14:7];
    assign req.rx_avail = s_axis_tdata[15];
    assign req.tx_room = s_axis_tdata[16];
    assign req.rx_byte = s_axis_tdata[24:17];
    assign req.pin = s_axis_tdata[27:25];

    duart_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    duart_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .console_port (console_reg),
        .req          (req),
        .cmd          (cmd),
        .stat         (stat),
        .result       (res)
    );

    assign m_axis_tdata = res;
endmodule
`default_nettype wire
